// ===== hdl/positional_insert_remove_list_defines.svh =====
// ----------------------------------------------------------------------------
// positional_insert_remove_list_defines.svh
// Assertion macros shared by the list RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_REMOVE_LIST_DEFINES_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_DEFINES_SVH

// condition must hold in the same cycle
`define PIRL_ASSERT_NOW(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define PIRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pirl_pkg.sv =====
// ----------------------------------------------------------------------------
// pirl_pkg
// Shared constants and types for the positional insert/remove list.
// ----------------------------------------------------------------------------
package pirl_pkg;

   localparam int DEPTH_DEFAULT       = 1024;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int GROUP_SIZE          = 32;   // cells per first-level read group

   localparam int OP_W       = 3;
   localparam int POSITION_W = 11;
   localparam int DATA_W     = 32;
   localparam int COUNT_W    = 11;
   localparam int STATUS_W   = 2;
   // internal position/count compare width, covers the largest list (4096)
   localparam int POS_W      = 13;

   localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd3;
   localparam logic [OP_W-1:0] OP_REM_TAIL = 3'd4;
   localparam logic [OP_W-1:0] OP_REM_POS  = 3'd5;
   localparam logic [OP_W-1:0] OP_READ     = 3'd6;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   typedef enum logic [1:0] {
      IDLE_S,
      EXEC_S,
      REDUCE_S
   } state_type;

   // broadcast to every cell during the execute cycle
   typedef struct packed {
      logic             shift_up;    // insert: open a hole at where
      logic             shift_down;  // remove: close the gap at where
      logic             sel_en;      // drive the cell at where onto the read tree
      logic [POS_W-1:0] where;
   } cell_ctrl_type;

endpackage

// ===== hdl/pirl_cell.sv =====
// ----------------------------------------------------------------------------
// pirl_cell
// One list slot: holds a value, takes its left or right neighbor or the inserted value on a shift.
// ----------------------------------------------------------------------------
module pirl_cell import pirl_pkg::*; #(
   parameter int INDEX       = 0,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic [VALUE_WIDTH-1:0] ins_value,
   input  logic [VALUE_WIDTH-1:0] left_data,
   input  logic [VALUE_WIDTH-1:0] right_data,
   output logic [VALUE_WIDTH-1:0] data,
   output logic [VALUE_WIDTH-1:0] tap
);

   localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

   logic [VALUE_WIDTH-1:0] data_ff;
   logic [VALUE_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (MY_POS > ctrl.where) begin
            data_in = left_data;
         end else if (MY_POS == ctrl.where) begin
            data_in = ins_value;
         end
      end else if (ctrl.shift_down) begin
         if (MY_POS >= ctrl.where) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = (ctrl.sel_en && (MY_POS == ctrl.where)) ? data_ff : '0;

endmodule

// ===== hdl/pirl_tree.sv =====
// ----------------------------------------------------------------------------
// pirl_tree
// Read-out tree: ORs the masked cell taps, one registered level of groups.
// ----------------------------------------------------------------------------
module pirl_tree import pirl_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   capture,
   input  logic [VALUE_WIDTH-1:0] tap [DEPTH],
   output logic [VALUE_WIDTH-1:0] sum
);

   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [VALUE_WIDTH-1:0] group_ff [NUM_GROUPS];
   logic [VALUE_WIDTH-1:0] group_in [NUM_GROUPS];

   genvar g;
   generate
      for (g = 0; g < NUM_GROUPS; g++) begin : gen_group
         always_comb begin
            group_in[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
               if (g * GROUP_SIZE + k < DEPTH) begin
                  group_in[g] = group_in[g] | tap[g * GROUP_SIZE + k];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (capture) begin
               group_ff[g] <= group_in[g];
            end
         end
      end
   endgenerate

   always_comb begin
      sum = '0;
      for (int n = 0; n < NUM_GROUPS; n++) begin
         sum = sum | group_ff[n];
      end
   end

endmodule

// ===== hdl/positional_insert_remove_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_remove_list
// Ordered list of up to DEPTH values held in a row of shifting cells.
//
// Request channel (req_*): one list operation per beat (op, position,
// entry_value). Response channel (rsp_*): exactly one beat per request with
// status, the removed or read value (zero otherwise) and the entry count
// after the operation. Both channels use valid/stall.
// A request accepted in IDLE_S runs through EXEC_S, where every cell
// shifts at once and the read-out groups capture, and then REDUCE_S,
// where the final OR of the two-level read-out tree goes into the
// response register. req_stall is high outside IDLE_S, so no new request
// is taken until the last one has left REDUCE_S.
// A new request is taken while an earlier response still waits; if the
// receiver stalls, the next result is held back in the read-out stage and
// req_stall stays high until the response register frees up.
// Reset empties the list (count 0); cell contents are left as they are
// and are never visible, since reads only reach positions below count.
// Full, empty and bad-position cases return a status and leave the list.
// ----------------------------------------------------------------------------
`include "positional_insert_remove_list_defines.svh"

module positional_insert_remove_list import pirl_pkg::*; #(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_op,
   input  logic [POSITION_W-1:0] req_position,
   input  logic [DATA_W-1:0]     req_entry_value,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_W-1:0]     rsp_out_value,
   output logic [COUNT_W-1:0]    rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   state_type state_ff, state_in;

   logic [OP_W-1:0]        op_ff, op_in;
   logic [POSITION_W-1:0]  pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [STATUS_W-1:0]    status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                   req_beat;
   logic                   rsp_free;
   cell_ctrl_type          ctrl;
   logic [POS_W-1:0]       count_pos;
   logic [POS_W-1:0]       where;

   logic [VALUE_WIDTH+DATA_W-1:0] val_wide;
   logic [VALUE_WIDTH+DATA_W-1:0] sum_wide;
   logic [CW+COUNT_W-1:0]         count_wide;

   logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_tap  [DEPTH];
   logic [VALUE_WIDTH-1:0] tree_sum;

   assign req_stall = (state_ff != IDLE_S);
   assign req_beat  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign val_wide   = {{VALUE_WIDTH{1'b0}}, req_entry_value};
   assign sum_wide   = {{DATA_W{1'b0}}, tree_sum};
   assign count_wide = {{COUNT_W{1'b0}}, count_ff};
   assign count_pos  = POS_W'(count_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      ctrl          = '0;
      where         = '0;

      unique case (state_ff)
         IDLE_S: begin
            if (req_beat) begin
               op_in    = req_op;
               pos_in   = req_position;
               val_in   = val_wide[VALUE_WIDTH-1:0];
               state_in = EXEC_S;
            end
         end

         EXEC_S: begin
            status_in = STATUS_OK;
            case (op_ff) inside
               OP_INS_HEAD, OP_REM_HEAD: where = '0;
               OP_INS_TAIL:              where = count_pos;
               OP_REM_TAIL:              where = count_pos - 1'b1;
               default:                  where = POS_W'(pos_ff);
            endcase
            ctrl.where = where;

            case (op_ff) inside
               OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else if (where > count_pos) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     ctrl.shift_up = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end
               OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS, OP_READ: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else if (where >= count_pos) begin
                     status_in = STATUS_RANGE;
                  end else begin
                     ctrl.sel_en = 1'b1;
                     if (op_ff != OP_READ) begin
                        ctrl.shift_down = 1'b1;
                        count_in        = count_ff - 1'b1;
                     end
                  end
               end
               default: ;  // unused code: no operation
            endcase
            state_in = REDUCE_S;
         end

         REDUCE_S: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = sum_wide[DATA_W-1:0];
               rsp_count_in  = count_wide[COUNT_W-1:0];
               state_in      = IDLE_S;
            end
         end

         default: state_in = IDLE_S;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_S;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : gen_cell
         logic [VALUE_WIDTH-1:0] left_data;
         logic [VALUE_WIDTH-1:0] right_data;

         if (i == 0) begin : gen_first
            assign left_data = '0;
         end else begin : gen_left
            assign left_data = cell_data[i-1];
         end

         // last cell fills with zero when the list closes up
         if (i == DEPTH - 1) begin : gen_last
            assign right_data = '0;
         end else begin : gen_right
            assign right_data = cell_data[i+1];
         end

         pirl_cell #(
            .INDEX       (i),
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .ins_value  (val_ff),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
         );
      end
   endgenerate

   pirl_tree #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_tree (
      .clock   (clock),
      .capture (state_ff == EXEC_S),
      .tap     (cell_tap),
      .sum     (tree_sum)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;

   `PIRL_ASSERT_NOW(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count beyond depth")
   `PIRL_ASSERT_NEXT(a_count_only_exec, clock, reset, state_ff != EXEC_S, $stable(count_ff), "count moved outside execute")
   `PIRL_ASSERT_NEXT(a_full_holds, clock, reset, state_ff == EXEC_S && status_in == STATUS_FULL, count_ff == CW'(DEPTH), "full insert changed count")
   `PIRL_ASSERT_NEXT(a_req_to_exec, clock, reset, req_beat, state_ff == EXEC_S, "accepted beat not executed")

endmodule
